/* design/assert_macros.svh */
// Assertion helpers used by merge_insertion_sorter_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, skipped while rst is high.
`define MIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define MIS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/mis_pkg.sv */
package mis_pkg;

  localparam int VALUE_W       = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_in;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      dropped;
  } result_t;

  // Contents of one cell of the chain.
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
  } slot_t;

  // Commands broadcast to every cell.
  typedef struct packed {
    logic                      insert;
    logic                      shift;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

endpackage

/* design/mis_cell.sv */
module mis_cell
  import mis_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  slot_t      left,
  input  logic       left_lt,
  input  slot_t      right,
  output slot_t      slot,
  output logic       lt
);

  slot_t slot_next;

  // An empty cell counts as +infinity; equal values stay ahead of the new one.
  assign lt = !slot.valid || (ctrl.value < slot.value);

  always_comb begin
    slot_next = slot;
    priority if (ctrl.shift) begin
      slot_next = right;
    end else if (ctrl.insert && lt) begin
      if (left_lt) begin
        slot_next = left;
      end else begin
        slot_next.valid = 1'b1;
        slot_next.value = ctrl.value;
      end
    end else begin
      slot_next = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.value <= slot_next.value;
  end

endmodule

/* design/merge_insertion_sorter_core.sv */
// Channel  | Direction | Handshake                    | Payload
// item     | in        | item_valid / item_ready      | item_t   (value, last_in)
// result   | out       | result_valid / result_ready  | result_t (sorted_value,
//          |           |                              |           last_out, dropped)
//
// Filling: one word per cycle; each word is placed in the cell chain the cycle
//   it is accepted, by a compare in every cell at once.
// Draining: after the word marked last_in, the list leaves one word per cycle
//   from cell 0 while result_ready is high, as the chain shifts left.
// item_ready is low for the whole drain; the next list starts after last_out.
// Reset clears the cell valid bits, the drop flag and the state; no pass.
// A stall on result holds the chain; words beyond MAX_ITEMS are dropped.
`include "assert_macros.svh"

module merge_insertion_sorter_core
  import mis_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  state_t     state;
  state_t     state_next;
  logic       overflow;
  logic       overflow_next;
  cell_ctrl_t ctrl;
  slot_t      slots [MAX_ITEMS];
  logic       lts   [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] valids;
  logic       item_fire;
  logic       result_fire;
  logic       full;

  assign item_fire   = item_valid && item_ready;
  assign result_fire = result_valid && result_ready;
  assign full        = slots[MAX_ITEMS-1].valid;

  // Broadcast commands: insert while filling and not full, shift on each taken word.
  assign ctrl.insert = item_fire && !full;
  assign ctrl.shift  = result_fire;
  assign ctrl.value  = item.value;

  // Chain of cells: each looks at its left and right neighbor only.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    slot_t left_s;
    slot_t right_s;
    logic  left_lt_s;

    if (i == 0) begin : g_first
      assign left_s    = '{valid: 1'b1, value: '0};
      assign left_lt_s = 1'b0;
    end else begin : g_mid_left
      assign left_s    = slots[i-1];
      assign left_lt_s = lts[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign right_s = '{valid: 1'b0, value: '0};
    end else begin : g_mid_right
      assign right_s = slots[i+1];
    end

    mis_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .left    (left_s),
      .left_lt (left_lt_s),
      .right   (right_s),
      .slot    (slots[i]),
      .lt      (lts[i])
    );

    assign valids[i] = slots[i].valid;
  end

  // Next state: drain after the marked word, refill after the greatest word leaves.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (item_fire && item.last_in) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (result_fire && result.last_out) begin
          state_next = ST_FILL;
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    item_ready   = 1'b0;
    result_valid = 1'b0;
    unique case (state)
      ST_FILL:  item_ready   = 1'b1;
      ST_DRAIN: result_valid = 1'b1;
      default: begin
        item_ready   = 1'b0;
        result_valid = 1'b0;
      end
    endcase
  end

  // Hold the drop flag for the list; drop it once the list has left.
  always_comb begin
    overflow_next = overflow;
    priority if (result_fire && result.last_out) begin
      overflow_next = 1'b0;
    end else if (item_fire && full) begin
      overflow_next = 1'b1;
    end else begin
      overflow_next = overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FILL;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      overflow <= overflow_next;
    end
  end

  assign result.sorted_value = slots[0].value;
  assign result.last_out     = !slots[1].valid;
  assign result.dropped      = overflow;

  // Filled cells always form an unbroken run from cell 0.
  `MIS_ASSERT(a_valid_run, ((valids + 1'b1) & valids) == '0, "chain has a gap")
  // A drain always has a word in cell 0.
  `MIS_ASSERT(a_drain_nonempty, (state == ST_DRAIN) |-> slots[0].valid, "drain with empty chain")
  // After the final word of a burst the chain is empty.
  `MIS_ASSERT(a_empty_after_last, (result_fire && result.last_out) |=> (valids == '0), "chain not empty after burst")
  // A word taken while full marks the list as dropped.
  `MIS_ASSERT(a_drop_flag, (item_fire && full) |=> overflow, "drop not recorded")

endmodule
